// ===== hdl/bla_pkg.sv =====
// Shared constants, types and helpers for the banded local alignment unit.
// Used by every module of the block except bla_ram; depends on nothing.
package bla_pkg;

    localparam int MAX_LEN    = 64;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int ROW_STRIDE = MAX_LEN + 1;
    localparam int CELL_DEPTH = ROW_STRIDE * ROW_STRIDE;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);
    localparam int SYM_W      = 8;
    localparam int CELL_W     = 9;
    localparam int CELL_MAX   = 511;
    localparam int SCORE_W    = CELL_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [1:0] {
        CMD_LOAD_Q = 2'd0,
        CMD_LOAD_R = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load_q;
        logic load_r;
        logic run_start;
        logic clr_step;
        logic row_setup;
        logic cell_up;
        logic cell_dg;
        logic cell_calc;
        logic tb_start;
        logic tb_dg;
        logic tb_up;
        logic tb_step;
        logic finish;
    } bla_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic rows_done;
        logic row_empty;
        logic row_end;
        logic tb_stop;
        logic tb_zero;
    } bla_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [LEN_W-1:0] row,
                                                    input logic [LEN_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(ROW_STRIDE) + ADDR_W'(col);
    endfunction

endpackage

// ===== hdl/bla_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bla_datapath.sv =====
// Datapath: sequence stores, score matrix, cell arithmetic, band and traceback.
// Depends on bla_pkg and bla_ram; driven by bla_ctrl commands.
module bla_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bla_pkg::bla_cmd_t                 cmd,
    input  logic [bla_pkg::SYM_W-1:0]         symbol,
    input  logic [2:0]                        match_bonus,
    input  logic signed [3:0]                 mismatch_bonus,
    input  logic signed [3:0]                 gap_cost,
    input  logic [5:0]                        band_extra,
    input  logic                              banded_mode,
    output bla_pkg::bla_stat_t                stat,
    output logic [bla_pkg::CELL_W-1:0]        best_score,
    output logic [bla_pkg::LEN_W-1:0]         best_column,
    output logic [bla_pkg::LEN_W-1:0]         match_count,
    output logic                              overflow
);

    localparam int LW = bla_pkg::LEN_W;
    localparam int SW = bla_pkg::SCORE_W;
    localparam int CW = bla_pkg::CELL_W;

    logic [LW-1:0] qlen_reg, rlen_reg;
    logic          dropped_reg;
    logic [LW-1:0] i_reg, j_reg, lo_reg, hi_reg;
    logic [bla_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [CW-1:0] best_reg, up_reg, dg_reg, here_reg, left_reg;
    logic [LW-1:0] bcol_reg, mcnt_reg;

    logic [LW-1:0] im1, jm1, lo_c, hi_c;
    logic [LW:0]   hsum;
    logic q_full, r_full;
    logic [bla_pkg::SYM_W-1:0] q_sym, r_sym;
    logic [CW-1:0] score_rdata, v_cell, wdata;
    logic [bla_pkg::ADDR_W-1:0] raddr, waddr;
    logic          score_we;
    logic signed [SW-1:0] pair, gap_s, d_s, u_s, l_s, v_s, here_s, dgt_s, upt_s;

    assign im1 = i_reg - 1'b1;
    assign jm1 = j_reg - 1'b1;
    assign q_full = (qlen_reg == LW'(bla_pkg::MAX_LEN));
    assign r_full = (rlen_reg == LW'(bla_pkg::MAX_LEN));

    bla_ram #(.WIDTH(bla_pkg::SYM_W), .DEPTH(bla_pkg::MAX_LEN)) u_qram (
        .aclk (aclk),
        .we   (cmd.load_q && !q_full),
        .waddr(qlen_reg[bla_pkg::IDX_W-1:0]),
        .wdata(symbol),
        .raddr(im1[bla_pkg::IDX_W-1:0]),
        .rdata(q_sym)
    );

    bla_ram #(.WIDTH(bla_pkg::SYM_W), .DEPTH(bla_pkg::MAX_LEN)) u_rram (
        .aclk (aclk),
        .we   (cmd.load_r && !r_full),
        .waddr(rlen_reg[bla_pkg::IDX_W-1:0]),
        .wdata(symbol),
        .raddr(jm1[bla_pkg::IDX_W-1:0]),
        .rdata(r_sym)
    );

    bla_ram #(.WIDTH(CW), .DEPTH(bla_pkg::CELL_DEPTH)) u_sram (
        .aclk (aclk),
        .we   (score_we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(score_rdata)
    );

    // band bounds for the row about to start
    always_comb begin
        hsum = (LW+1)'(bcol_reg) + (LW+1)'(band_extra) + 1'b1;
        if (banded_mode) begin
            lo_c = (bcol_reg > LW'(1)) ? bcol_reg : LW'(1);
            hi_c = (hsum > (LW+1)'(rlen_reg)) ? rlen_reg : hsum[LW-1:0];
        end else begin
            lo_c = LW'(1);
            hi_c = rlen_reg;
        end
    end

    always_comb begin
        if (cmd.cell_up || cmd.tb_up) begin
            raddr = bla_pkg::cell_addr(im1, j_reg);
        end else if (cmd.cell_dg || cmd.tb_dg) begin
            raddr = bla_pkg::cell_addr(im1, jm1);
        end else begin
            raddr = bla_pkg::cell_addr(i_reg, j_reg);
        end
    end

    // cell arithmetic, 11-bit signed
    always_comb begin
        pair  = (q_sym == r_sym) ? SW'($signed({1'b0, match_bonus}))
                                 : SW'(mismatch_bonus);
        gap_s = SW'(gap_cost);
        d_s   = $signed(SW'(score_rdata)) + pair;
        u_s   = $signed(SW'(up_reg)) + gap_s;
        l_s   = ((j_reg == lo_reg) ? $signed(SW'(0)) : $signed(SW'(left_reg))) + gap_s;
        v_s   = '0;
        if (d_s > v_s) v_s = d_s;
        if (u_s > v_s) v_s = u_s;
        if (l_s > v_s) v_s = l_s;
        v_cell = (v_s > SW'(bla_pkg::CELL_MAX)) ? CW'(bla_pkg::CELL_MAX) : v_s[CW-1:0];
        here_s = $signed(SW'(here_reg));
        dgt_s  = $signed(SW'(dg_reg)) + pair;
        upt_s  = $signed(SW'(score_rdata)) + gap_s;
    end

    assign score_we = cmd.clr_step || cmd.cell_calc;
    assign waddr    = cmd.clr_step ? clr_addr_reg : bla_pkg::cell_addr(i_reg, j_reg);
    assign wdata    = cmd.clr_step ? '0 : v_cell;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg    <= '0;
            rlen_reg    <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.finish) begin
            qlen_reg    <= '0;
            rlen_reg    <= '0;
            dropped_reg <= 1'b0;
        end else begin
            if (cmd.load_q) begin
                if (q_full) dropped_reg <= 1'b1;
                else        qlen_reg    <= qlen_reg + 1'b1;
            end
            if (cmd.load_r) begin
                if (r_full) dropped_reg <= 1'b1;
                else        rlen_reg    <= rlen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.run_start) begin
            clr_addr_reg <= '0;
            i_reg        <= LW'(1);
            best_reg     <= '0;
            bcol_reg     <= '0;
            mcnt_reg     <= '0;
        end
        if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
        if (cmd.row_setup) begin
            lo_reg <= lo_c;
            hi_reg <= hi_c;
            j_reg  <= lo_c;
            if (lo_c > hi_c) i_reg <= i_reg + 1'b1;
        end
        if (cmd.cell_dg) begin
            up_reg <= score_rdata;
        end
        if (cmd.cell_calc) begin
            left_reg <= v_cell;
            if (v_cell > best_reg) begin
                best_reg <= v_cell;
                bcol_reg <= j_reg;
            end
            if (j_reg == hi_reg) i_reg <= i_reg + 1'b1;
            else                 j_reg <= j_reg + 1'b1;
        end
        if (cmd.tb_start) begin
            i_reg <= qlen_reg;
            j_reg <= bcol_reg;
        end
        if (cmd.tb_dg) begin
            here_reg <= score_rdata;
        end
        if (cmd.tb_up) begin
            dg_reg <= score_rdata;
        end
        if (cmd.tb_step) begin
            if (here_s == dgt_s) begin
                if (q_sym == r_sym) mcnt_reg <= mcnt_reg + 1'b1;
                i_reg <= im1;
                j_reg <= jm1;
            end else if (here_s == upt_s) begin
                i_reg <= im1;
            end else begin
                j_reg <= jm1;
            end
        end
    end

    assign stat.clr_done  = (clr_addr_reg == bla_pkg::ADDR_W'(bla_pkg::CELL_DEPTH - 1));
    assign stat.rows_done = (i_reg > qlen_reg);
    assign stat.row_empty = (lo_c > hi_c);
    assign stat.row_end   = (j_reg == hi_reg);
    assign stat.tb_stop   = (i_reg == '0) || (j_reg == '0);
    assign stat.tb_zero   = (score_rdata == '0);

    assign best_score  = best_reg;
    assign best_column = bcol_reg;
    assign match_count = mcnt_reg;
    assign overflow    = dropped_reg;

endmodule

// ===== hdl/bla_ctrl.sv =====
// Controller: sequences loads, matrix clear, row fill and traceback.
// Depends on bla_pkg; drives bla_datapath through command/status structs.
module bla_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  bla_pkg::cmd_code_t  in_command,
    input  logic                out_free,
    input  bla_pkg::bla_stat_t  stat,
    output logic                in_ready,
    output bla_pkg::bla_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_ROW, ST_C_UP, ST_C_DG, ST_C_CALC,
        ST_T_HERE, ST_T_DG, ST_T_UP, ST_T_DEC, ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_command)
                        bla_pkg::CMD_LOAD_Q: cmd.load_q = 1'b1;
                        bla_pkg::CMD_LOAD_R: cmd.load_r = 1'b1;
                        bla_pkg::CMD_RUN: begin
                            cmd.run_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = ST_ROW;
            end
            ST_ROW: begin
                if (stat.rows_done) begin
                    cmd.tb_start = 1'b1;
                    state_next   = ST_T_HERE;
                end else begin
                    cmd.row_setup = 1'b1;
                    if (!stat.row_empty) state_next = ST_C_UP;
                end
            end
            ST_C_UP: begin
                cmd.cell_up = 1'b1;
                state_next  = ST_C_DG;
            end
            ST_C_DG: begin
                cmd.cell_dg = 1'b1;
                state_next  = ST_C_CALC;
            end
            ST_C_CALC: begin
                cmd.cell_calc = 1'b1;
                state_next    = stat.row_end ? ST_ROW : ST_C_UP;
            end
            ST_T_HERE: begin
                state_next = stat.tb_stop ? ST_FINISH : ST_T_DG;
            end
            ST_T_DG: begin
                cmd.tb_dg  = 1'b1;
                state_next = stat.tb_zero ? ST_FINISH : ST_T_UP;
            end
            ST_T_UP: begin
                cmd.tb_up  = 1'b1;
                state_next = ST_T_DEC;
            end
            ST_T_DEC: begin
                cmd.tb_step = 1'b1;
                state_next  = ST_T_HERE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== hdl/banded_local_alignment_unit.sv =====
// Top level of the banded local alignment unit: ports, config registers, result word.
// Depends on bla_pkg, bla_ctrl, bla_datapath (and bla_ram below them).
//
// Usage: load query symbols (command 0) and reference symbols (command 1), one word
// per cycle while the unit is idle, up to 64 each; extra loads are dropped and flagged.
// A run word (command 2) clears the 65x65 score matrix, fills it row by row with
// linear-gap local alignment scores (banded around the best column or full, per
// banded_mode), then walks back from the last row and best column counting
// equal-symbol diagonal steps. One result word follows each run; loads and unused
// commands give none. After a run both sequences and the overflow flag start afresh.
// The matrix clear writes one entry per cycle through the single write port. The fill
// sets up each row's band, then per computed cell does two score reads through the
// one read port, then the write. Each traceback step reads the cell, its diagonal and
// upper neighbours, then moves; the result is then handed over, waiting while an
// earlier result still waits on m_tready. No word is taken while a run is in progress;
// loads are taken while a finished result still waits on m_tready. Configuration must
// be written only while idle; the block itself does not enforce this.
module banded_local_alignment_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] command, [9:2] symbol, [15:10] zero
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] best_score, [15:9] best_column,
                                   // [22:16] match_count, [23] overflow
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bla_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [2:0]        match_reg;
    logic signed [3:0] mismatch_reg;
    logic signed [3:0] gap_reg;
    logic [5:0]        band_reg;
    logic              mode_reg;

    logic               in_accept, out_free, m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    bla_pkg::bla_cmd_t  cmd;
    bla_pkg::bla_stat_t stat;
    logic [bla_pkg::CELL_W-1:0] best_score;
    logic [bla_pkg::LEN_W-1:0]  best_column, match_count;
    logic                       overflow;

    // config registers, reset to the documented defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg    <= 3'd2;
            mismatch_reg <= 4'sd1;
            gap_reg      <= -4'sd1;
            band_reg     <= 6'd1;
            mode_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bla_pkg::CFG_MATCH:    match_reg    <= cfg_wdata[2:0];
                bla_pkg::CFG_MISMATCH: mismatch_reg <= cfg_wdata[3:0];
                bla_pkg::CFG_GAP:      gap_reg      <= cfg_wdata[3:0];
                bla_pkg::CFG_BAND:     band_reg     <= cfg_wdata[5:0];
                bla_pkg::CFG_MODE:     mode_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;
    // output register empty, or being drained this cycle
    assign out_free  = !m_tvalid_reg || m_tready;

    bla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_command(bla_pkg::cmd_code_t'(s_tdata[1:0])),
        .out_free  (out_free),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    bla_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .symbol        (s_tdata[9:2]),
        .match_bonus   (match_reg),
        .mismatch_bonus(mismatch_reg),
        .gap_cost      (gap_reg),
        .band_extra    (band_reg),
        .banded_mode   (mode_reg),
        .stat          (stat),
        .best_score    (best_score),
        .best_column   (best_column),
        .match_count   (match_count),
        .overflow      (overflow)
    );

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {overflow, match_count, best_column, best_score};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for banded_local_alignment_unit: loads sequences, runs jobs,
// predicts each result word in a scoreboard class. Depends on bla_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    // Scoreboard: own copy of sequences and registers, predicts each run
    class align_scoreboard;
        logic [7:0]  q_sym[bla_pkg::MAX_LEN];
        logic [7:0]  r_sym[bla_pkg::MAX_LEN];
        int          q_len, r_len;
        bit          dropped;
        int          match_b, mismatch_b, gap_c, band_x;
        bit          banded;
        logic [23:0] pending[$];
        int          errors, mism_shown;

        function void reset_state();
            q_len = 0; r_len = 0; dropped = 0;
            match_b = 2; mismatch_b = 1; gap_c = -1; band_x = 1; banded = 1;
            pending.delete();
            errors = 0; mism_shown = 0;
        endfunction

        function void set_reg(logic [bla_pkg::CFG_IDX_W-1:0] idx,
                              logic [bla_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                bla_pkg::CFG_MATCH:    match_b    = v[2:0];
                bla_pkg::CFG_MISMATCH: mismatch_b = $signed(v[3:0]);
                bla_pkg::CFG_GAP:      gap_c      = $signed(v[3:0]);
                bla_pkg::CFG_BAND:     band_x     = v[5:0];
                bla_pkg::CFG_MODE:     banded     = v[0];
                default: ;
            endcase
        endfunction

        function int pair(logic [7:0] a, logic [7:0] b);
            return (a == b) ? match_b : mismatch_b;
        endfunction

        // note an accepted input word
        function void note_word(bla_pkg::cmd_code_t cmd, logic [7:0] sym);
            int  sc[bla_pkg::ROW_STRIDE][bla_pkg::ROW_STRIDE];
            int  best, bcol, lo, hi, v, i, j, hits;
            case (cmd)
                bla_pkg::CMD_LOAD_Q:
                    if (q_len < bla_pkg::MAX_LEN) begin q_sym[q_len] = sym; q_len++; end
                    else dropped = 1;
                bla_pkg::CMD_LOAD_R:
                    if (r_len < bla_pkg::MAX_LEN) begin r_sym[r_len] = sym; r_len++; end
                    else dropped = 1;
                bla_pkg::CMD_RUN: begin
                    best = 0; bcol = 0; hits = 0;
                    for (i = 0; i < bla_pkg::ROW_STRIDE; i++)
                        for (j = 0; j < bla_pkg::ROW_STRIDE; j++) sc[i][j] = 0;
                    for (i = 1; i <= q_len; i++) begin
                        lo = 1; hi = r_len;
                        if (banded) begin
                            lo = bcol > 1 ? bcol : 1;
                            hi = bcol + band_x + 1;
                            if (hi > r_len) hi = r_len;
                        end
                        for (j = lo; j <= hi; j++) begin
                            v = 0;
                            if (sc[i-1][j-1] + pair(q_sym[i-1], r_sym[j-1]) > v)
                                v = sc[i-1][j-1] + pair(q_sym[i-1], r_sym[j-1]);
                            if (sc[i-1][j] + gap_c > v) v = sc[i-1][j] + gap_c;
                            if (sc[i][j-1] + gap_c > v) v = sc[i][j-1] + gap_c;
                            if (v > bla_pkg::CELL_MAX) v = bla_pkg::CELL_MAX;
                            sc[i][j] = v;
                            if (v > best) begin best = v; bcol = j; end
                        end
                    end
                    // traceback from last row, best column
                    i = q_len; j = bcol;
                    while (i > 0 && j > 0 && sc[i][j] != 0) begin
                        if (sc[i][j] == sc[i-1][j-1] + pair(q_sym[i-1], r_sym[j-1])) begin
                            if (q_sym[i-1] == r_sym[j-1]) hits++;
                            i--; j--;
                        end else if (sc[i][j] == sc[i-1][j] + gap_c) i--;
                        else j--;
                    end
                    pending.push_back({dropped, 7'(hits), 7'(bcol), 9'(best)});
                    q_len = 0; r_len = 0; dropped = 0;
                end
                default: ;
            endcase
        endfunction

        // check a result word against the oldest expectation
        function void check_result(logic [23:0] got);
            logic [23:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (mism_shown++ < 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (mism_shown++ < 10)
                    $display("mismatch: score %0d/%0d col %0d/%0d matches %0d/%0d ovf %0d/%0d",
                             want[8:0], got[8:0], want[15:9], got[15:9],
                             want[22:16], got[22:16], want[23], got[23]);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic                           cfg_wr_en = 0;
    logic [bla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bla_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    align_scoreboard board;
    int  send_idle_pct = 0;      // chance in 100 that the sender idles a cycle
    int  recv_stall_pct = 0;     // chance in 100 that the receiver stalls
    int  runs_seen = 0;
    int  words_sent = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    banded_local_alignment_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // receiver: random back-pressure, check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
            runs_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // send one input word; idle gaps come before it, valid held until taken
    task automatic send_word(bla_pkg::cmd_code_t cmd, logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {6'd0, sym, cmd};
        do @(posedge aclk); while (!s_tready);
        board.note_word(cmd, sym);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [bla_pkg::CFG_IDX_W-1:0] idx,
                             logic [bla_pkg::CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic set_all(int mb, int mm, int gc, int bx, int md);
        write_reg(bla_pkg::CFG_MATCH, 6'(mb));
        write_reg(bla_pkg::CFG_MISMATCH, 6'(4'(mm)));
        write_reg(bla_pkg::CFG_GAP, 6'(4'(gc)));
        write_reg(bla_pkg::CFG_BAND, 6'(bx));
        write_reg(bla_pkg::CFG_MODE, 6'(md));
    endtask

    // one job: short sequences mostly, small alphabet so matches happen;
    // now and then a full-length or overfilled one
    task automatic random_job();
        int qn, rn, alpha, k;
        alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 4);
        qn = ($urandom_range(15) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
        rn = ($urandom_range(15) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
        while (qn > 0 || rn > 0) begin
            k = $urandom_range(9);
            if (k == 0) send_word(bla_pkg::CMD_NONE, 8'($urandom));
            else if ((k < 5 && qn > 0) || rn == 0) begin
                send_word(bla_pkg::CMD_LOAD_Q, 8'($urandom_range(alpha))); qn--;
            end else begin
                send_word(bla_pkg::CMD_LOAD_R, 8'($urandom_range(alpha))); rn--;
            end
        end
        send_word(bla_pkg::CMD_RUN, 8'($urandom));
    endtask

    initial begin
        int ph, k;
        board = new();
        board.reset_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty run, unused command, identical sequences, full and overfilled loads
        send_word(bla_pkg::CMD_RUN, 8'hFF);
        send_word(bla_pkg::CMD_NONE, 8'hA5);
        send_word(bla_pkg::CMD_LOAD_Q, 8'h00);
        send_word(bla_pkg::CMD_RUN, 8'h00);  // empty reference
        for (k = 0; k < 4; k++) send_word(bla_pkg::CMD_LOAD_Q, k[0] ? 8'hFF : 8'h00);
        for (k = 0; k < 4; k++) send_word(bla_pkg::CMD_LOAD_R, k[0] ? 8'hFF : 8'h00);
        send_word(bla_pkg::CMD_RUN, 8'h55);
        for (k = 0; k < 65; k++) send_word(bla_pkg::CMD_LOAD_Q, 8'hAA);  // one dropped
        for (k = 0; k < 65; k++) send_word(bla_pkg::CMD_LOAD_R, 8'hAA);
        send_word(bla_pkg::CMD_RUN, 8'h00);
        drain();

        // register settings, extremes included; idling phases rotate
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_all(7, 7, 0, 63, 1);     // big scores, widest band
                1: set_all(0, -7, -7, 0, 1);
                2: set_all(7, -7, -7, 0, 0);
                3: set_all(2, 1, -1, 1, 1);
                default: set_all($urandom_range(7), $urandom_range(14) - 7,
                                 -$urandom_range(7), $urandom_range(63), $urandom_range(1));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            k = words_sent;
            while (words_sent - k < 200) random_job();
            drain();
        end

        $display("Ran %0d input words and %0d alignment jobs over 8 register settings",
                 words_sent, runs_seen);
        $display("Errors counted: %0d", board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // timeout: bounds the whole test, allowing for stalls and a few hundred runs at most
    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
